[sv/lsb_pkg.sv]
// Shared widths, codes and types for the Lorentzian line broadening block.
// Used by every module of the block; depends on nothing else.
package lsb_pkg;

  // Field widths fixed by the ports
  localparam int unsigned FREQ_W     = 21;  // mode frequency, 1/16 cm^-1, signed
  localparam int unsigned INTEN_W    = 32;  // mode intensity, Q16.16
  localparam int unsigned MIDX_W     = 8;   // mode_index
  localparam int unsigned POINT_W    = 9;   // point_index
  localparam int unsigned GRIDF_W    = 12;  // grid_frequency
  localparam int unsigned SUM_W      = 48;  // spectrum_value
  localparam int unsigned WSQ_W      = 32;  // width_sq register
  localparam int unsigned MCOUNT_W   = 9;   // mode_count register
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Datapath widths
  localparam int unsigned GRID16_W   = 17;  // 160*k for a 9-bit k
  localparam int unsigned GRID10_W   = 13;  // 10*k before masking
  localparam int unsigned DIFF_W     = 22;  // signed grid - mode frequency
  localparam int unsigned DIST_W     = 21;  // |shift|
  localparam int unsigned SQ_W       = 2 * DIST_W;
  localparam int unsigned DEN_W      = SQ_W + 1;
  localparam int unsigned FACTOR_W   = 16;  // Q0.16 factor
  localparam int unsigned PROD_W     = INTEN_W + FACTOR_W;

  // Constants
  localparam logic [WSQ_W-1:0]    WIDTH_SQ_RESET = WSQ_W'(6400);  // 25 cm^-2
  localparam logic [GRID16_W-1:0] GRID_STEP16    = GRID16_W'(160);
  localparam logic [GRID10_W-1:0] GRID_STEP      = GRID10_W'(10);
  localparam logic [FACTOR_W-1:0] FACTOR_MAX     = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX        = '1;

  // Default sizes
  localparam int unsigned DEF_MODE_DEPTH  = 256;
  localparam int unsigned DEF_GRID_POINTS = 400;

  // Item action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SQ   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_COUNT = CFG_IDX_W'(1);

  // One table entry
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [INTEN_W-1:0] inten;
  } mode_entry_t;

  // One broadened term leaving the arithmetic pipeline
  typedef struct packed {
    logic               valid;
    logic [INTEN_W-1:0] term;
  } term_beat_t;

  // Query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

[sv/lsb_mode_mem.sv]
// Mode table: single-port-write, single-port-read synchronous memory.
// Read data is registered. Depends on lsb_pkg.
module lsb_mode_mem
  import lsb_pkg::*;
#(
  parameter int unsigned MODE_DEPTH = DEF_MODE_DEPTH,
  parameter int unsigned ADDR_W     = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  mode_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output mode_entry_t       rd_data,
  output logic              rd_valid
);

  mode_entry_t mem [MODE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

[sv/lsb_term_pipe.sv]
// Per-entry arithmetic pipeline: shift, shift^2, denominator, 16-stage
// restoring divide for the Q0.16 factor, then intensity*factor. Depends on lsb_pkg.
module lsb_term_pipe
  import lsb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  mode_entry_t         entry,
  input  logic [GRID16_W-1:0] grid16,
  input  logic [WSQ_W-1:0]    width_sq,
  output term_beat_t          beat
);

  // Stage 0: distance from grid point
  logic signed [DIFF_W-1:0] diff;
  logic [DIST_W-1:0]        shift_abs;
  logic [DIST_W-1:0]        s0_dist;
  logic [INTEN_W-1:0]       s0_inten;
  logic                     s0_vld;

  always_comb begin
    diff = $signed({{(DIFF_W-GRID16_W){1'b0}}, grid16})
         - $signed({{(DIFF_W-FREQ_W){entry.freq[FREQ_W-1]}}, entry.freq});
    shift_abs = diff[DIFF_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
  end

  always_ff @(posedge clk) begin
    s0_dist  <= shift_abs;
    s0_inten <= entry.inten;
  end

  // Stage 1: square
  logic [SQ_W-1:0]    s1_sq;
  logic [INTEN_W-1:0] s1_inten;
  logic               s1_vld;

  always_ff @(posedge clk) begin
    s1_sq    <= s0_dist * s0_dist;
    s1_inten <= s0_inten;
  end

  // Stage 2: denominator, special-case flags, divider seed
  logic [DEN_W-1:0] den_sum;
  assign den_sum = DEN_W'(width_sq) + DEN_W'(s1_sq);

  // Divider stage registers; index 0 is the seed
  logic [DEN_W-1:0]    dv_den   [FACTOR_W+1];
  logic [DEN_W-1:0]    dv_rem   [FACTOR_W+1];
  logic [FACTOR_W-1:0] dv_quo   [FACTOR_W+1];
  logic                dv_peak  [FACTOR_W+1];
  logic                dv_zero  [FACTOR_W+1];
  logic [INTEN_W-1:0]  dv_inten [FACTOR_W+1];
  logic                dv_vld   [FACTOR_W+1];

  always_ff @(posedge clk) begin
    dv_den[0]   <= den_sum;
    dv_rem[0]   <= DEN_W'(width_sq);
    dv_quo[0]   <= '0;
    dv_peak[0]  <= (s1_sq == '0);
    dv_zero[0]  <= (den_sum == '0);
    dv_inten[0] <= s1_inten;
  end

  // One quotient bit per stage
  for (genvar j = 0; j < FACTOR_W; j++) begin : g_div
    logic [DEN_W:0] rem2;
    logic           ge;

    always_comb begin
      rem2 = {dv_rem[j], 1'b0};
      ge   = (rem2 >= {1'b0, dv_den[j]});
    end

    always_ff @(posedge clk) begin
      dv_rem[j+1]   <= ge ? DEN_W'(rem2 - {1'b0, dv_den[j]}) : DEN_W'(rem2);
      dv_quo[j+1]   <= {dv_quo[j][FACTOR_W-2:0], ge};
      dv_den[j+1]   <= dv_den[j];
      dv_peak[j+1]  <= dv_peak[j];
      dv_zero[j+1]  <= dv_zero[j];
      dv_inten[j+1] <= dv_inten[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end
  end

  // Final factor: zero denominator gives 0, exact peak clips to max
  logic [FACTOR_W-1:0] factor;
  always_comb begin
    if (dv_zero[FACTOR_W]) begin
      factor = '0;
    end else if (dv_peak[FACTOR_W]) begin
      factor = FACTOR_MAX;
    end else begin
      factor = dv_quo[FACTOR_W];
    end
  end

  // Output stage: term = intensity * factor >> 16
  logic [PROD_W-1:0]  prod;
  logic [INTEN_W-1:0] term_q;
  logic               term_vld;
  assign prod = PROD_W'(dv_inten[FACTOR_W]) * PROD_W'(factor);

  always_ff @(posedge clk) begin
    term_q <= prod[PROD_W-1:FACTOR_W];
  end

  assign beat.term  = term_q;
  assign beat.valid = term_vld;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld    <= 1'b0;
      s1_vld    <= 1'b0;
      dv_vld[0] <= 1'b0;
      term_vld  <= 1'b0;
    end else begin
      s0_vld    <= in_vld;
      s1_vld    <= s0_vld;
      dv_vld[0] <= s1_vld;
      term_vld  <= dv_vld[FACTOR_W];
    end
  end

endmodule

[sv/lsb_query_ctrl.sv]
// Item sequencer: table loads, query walk over the table, saturating
// accumulation and the output register. Depends on lsb_pkg.
module lsb_query_ctrl
  import lsb_pkg::*;
#(
  parameter int unsigned MODE_DEPTH  = DEF_MODE_DEPTH,
  parameter int unsigned GRID_POINTS = DEF_GRID_POINTS,
  parameter int unsigned ADDR_W      = 8,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [MIDX_W-1:0]   mode_index,
  input  logic [FREQ_W-1:0]   mode_frequency,
  input  logic [INTEN_W-1:0]  mode_intensity,
  input  logic [POINT_W-1:0]  point_index,
  // configuration
  input  logic [MCOUNT_W-1:0] mode_count,
  // table access
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output mode_entry_t         wr_data,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  // arithmetic pipeline
  output logic [GRID16_W-1:0] grid16,
  input  term_beat_t          beat,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GRIDF_W-1:0]  grid_frequency,
  output logic [SUM_W-1:0]    spectrum_value,
  output logic                saturated
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   issue_cnt;
  logic [CNT_W-1:0]   recv_cnt;
  logic [CNT_W-1:0]   n_cnt;
  logic [GRIDF_W-1:0] gridf;
  logic [SUM_W-1:0]   sum;
  logic               sat;

  logic               accept;
  logic               point_ok;
  logic               start;
  logic               load_out;
  logic [CNT_W-1:0]   n_lim;
  logic [GRID10_W-1:0] grid10;
  logic [SUM_W:0]     sum_add;

  // Items are taken only between queries
  assign in_ready = (state == ST_IDLE);

  assign accept   = in_valid && in_ready;
  assign point_ok = (point_index != '0) && (32'(point_index) <= 32'(GRID_POINTS));
  assign start    = accept && (action == ACT_QUERY) && point_ok;
  assign n_lim    = (32'(mode_count) > 32'(MODE_DEPTH)) ? CNT_W'(MODE_DEPTH)
                                                        : CNT_W'(mode_count);
  assign grid10   = GRID10_W'(point_index) * GRID_STEP;

  // Table write for load beats; out-of-range indexes are dropped
  assign wr_en         = accept && (action == ACT_LOAD)
                      && (32'(mode_index) < 32'(MODE_DEPTH));
  assign wr_addr       = ADDR_W'(mode_index);
  assign wr_data.freq  = mode_frequency;
  assign wr_data.inten = mode_intensity;

  assign rd_addr = issue_cnt[ADDR_W-1:0];

  // Next state and control outputs
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (n_lim == '0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        rd_en = 1'b1;
        if (issue_cnt == n_cnt - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (beat.valid && (recv_cnt == n_cnt - CNT_W'(1))) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query setup and table walk
  always_ff @(posedge clk) begin
    if (start) begin
      issue_cnt <= '0;
      n_cnt     <= n_lim;
      grid16    <= GRID16_W'(point_index) * GRID_STEP16;
      gridf     <= grid10[GRIDF_W-1:0];
    end else if (rd_en) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
  end

  // Saturating accumulation, sticky once clipped
  assign sum_add = {1'b0, sum} + (SUM_W+1)'(beat.term);

  always_ff @(posedge clk) begin
    if (start) begin
      recv_cnt <= '0;
      sum      <= '0;
      sat      <= 1'b0;
    end else if (beat.valid) begin
      recv_cnt <= recv_cnt + CNT_W'(1);
      if (sat || sum_add[SUM_W]) begin
        sum <= SUM_MAX;
        sat <= 1'b1;
      end else begin
        sum <= sum_add[SUM_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      grid_frequency <= gridf;
      spectrum_value <= sum;
      saturated      <= sat;
    end
  end

endmodule

[sv/lorentzian_spectrum_broadening_top.sv]
// Lorentzian line broadening: mode table, query sequencer, divide pipeline.
// Instantiates lsb_mode_mem, lsb_term_pipe and lsb_query_ctrl; uses lsb_pkg.
//
// A load beat writes one table entry. A query beat for grid point k sums,
// over the first min(mode_count, MODE_DEPTH) entries n, intensity * width_sq
// / (width_sq + shift^2): the single table read port streams one entry per
// cycle through the registered read and a 20-stage pipeline (shift, square,
// denominator, 16 one-bit divide stages, multiply); the last term is then
// added into the sum, and the sum is loaded into the output register. Items
// are handled one at a time; a finished result waits in the output register
// while the next item is taken, and a query that finds the register still
// full holds in its last step until the result is taken. The table has no
// reset; entries must be loaded before a query reads them. Configuration
// writes are always accepted and must land only while the block is idle.
module lorentzian_spectrum_broadening_top
  import lsb_pkg::*;
#(
  parameter int unsigned MODE_DEPTH  = DEF_MODE_DEPTH,
  parameter int unsigned GRID_POINTS = DEF_GRID_POINTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [MIDX_W-1:0]     mode_index,
  input  logic [FREQ_W-1:0]     mode_frequency,
  input  logic [INTEN_W-1:0]    mode_intensity,
  input  logic [POINT_W-1:0]    point_index,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [GRIDF_W-1:0]    grid_frequency,
  output logic [SUM_W-1:0]      spectrum_value,
  output logic                  saturated
);

  localparam int unsigned ADDR_W = (MODE_DEPTH > 1) ? $clog2(MODE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(MODE_DEPTH + 1);

  // Configuration registers
  logic [WSQ_W-1:0]    width_sq;
  logic [MCOUNT_W-1:0] mode_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_sq   <= WIDTH_SQ_RESET;
      mode_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH_SQ:   width_sq   <= cfg_data[WSQ_W-1:0];
        CFG_MODE_COUNT: mode_count <= cfg_data[MCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  mode_entry_t         wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  mode_entry_t         rd_data;
  logic                rd_valid;
  logic [GRID16_W-1:0] grid16;
  term_beat_t          beat;

  lsb_mode_mem #(
    .MODE_DEPTH (MODE_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  lsb_term_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rd_valid),
    .entry    (rd_data),
    .grid16   (grid16),
    .width_sq (width_sq),
    .beat     (beat)
  );

  lsb_query_ctrl #(
    .MODE_DEPTH  (MODE_DEPTH),
    .GRID_POINTS (GRID_POINTS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .mode_index     (mode_index),
    .mode_frequency (mode_frequency),
    .mode_intensity (mode_intensity),
    .point_index    (point_index),
    .mode_count     (mode_count),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .grid16         (grid16),
    .beat           (beat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grid_frequency (grid_frequency),
    .spectrum_value (spectrum_value),
    .saturated      (saturated)
  );

endmodule

[sim/lsb_spectrum_checker.sv]
// Scoreboard for the Lorentzian line broadening block: watches config, item and result beats.
// Predicts each query's spectrum point from its own mode table and register copies.
// Depends on lsb_pkg only.
`timescale 1ns / 100ps

module lsb_spectrum_checker
  import lsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  action,
  input  logic [MIDX_W-1:0]     mode_index,
  input  logic [FREQ_W-1:0]     mode_frequency,
  input  logic [INTEN_W-1:0]    mode_intensity,
  input  logic [POINT_W-1:0]    point_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [GRIDF_W-1:0]    grid_frequency,
  input  logic [SUM_W-1:0]      spectrum_value,
  input  logic                  saturated,
  output int                    errors,
  output int                    pending
);

  localparam int unsigned TABLE_DEPTH = DEF_MODE_DEPTH;
  localparam int unsigned GRID_LAST   = DEF_GRID_POINTS;

  typedef struct packed {
    logic [GRIDF_W-1:0] grid;
    logic [SUM_W-1:0]   value;
    logic               sat;
  } spectrum_point_t;

  logic [WSQ_W-1:0]    width_sq_q;
  logic [MCOUNT_W-1:0] mode_count_q;
  logic [FREQ_W-1:0]   freq_tab  [TABLE_DEPTH];
  logic [INTEN_W-1:0]  inten_tab [TABLE_DEPTH];
  spectrum_point_t     spectrum_q [$];

  // Q0.16 line shape width_sq / (width_sq + shift^2), clipped; zero denominator gives 0
  function automatic logic [FACTOR_W-1:0] line_shape(int unsigned k, logic [FREQ_W-1:0] freq);
    longint signed   shift;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned quot;
    shift = longint'(k) * longint'(GRID_STEP16) - longint'($signed(freq));
    mag   = (shift < 0) ? -shift : shift;
    den   = {32'b0, width_sq_q} + mag * mag;
    if (den == 0) return '0;
    quot = {16'b0, width_sq_q, 16'b0} / den;
    return (quot > {48'b0, FACTOR_MAX}) ? FACTOR_MAX : quot[FACTOR_W-1:0];
  endfunction

  // Sum of broadened terms over the leading table entries, saturating and sticky
  function automatic spectrum_point_t broaden(int unsigned k);
    spectrum_point_t pt;
    int unsigned     n;
    logic [63:0]     sum;
    logic [63:0]     term;
    logic            sat;
    n   = (mode_count_q > TABLE_DEPTH) ? TABLE_DEPTH : mode_count_q;
    sum = '0;
    sat = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      term = ({32'b0, inten_tab[i]} * line_shape(k, freq_tab[i])) >> FACTOR_W;
      if (sat || term > {16'b0, SUM_MAX} - sum) begin
        sum = {16'b0, SUM_MAX};
        sat = 1'b1;
      end else begin
        sum = sum + term;
      end
    end
    pt.grid  = GRIDF_W'(k * GRID_STEP);
    pt.value = sum[SUM_W-1:0];
    pt.sat   = sat;
    return pt;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Results are compared before the item of the same edge is predicted
  always @(posedge clk) begin
    spectrum_point_t want;
    if (rst) begin
      width_sq_q   = WIDTH_SQ_RESET;
      mode_count_q = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (spectrum_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected: expected nothing, got grid %0d value %0h",
                   $time, grid_frequency, spectrum_value);
        end else begin
          want = spectrum_q.pop_front();
          check_field("grid_frequency", want.grid, grid_frequency);
          check_field("spectrum_value", want.value, spectrum_value);
          check_field("saturated", want.sat, saturated);
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_LOAD) begin
          if (mode_index < TABLE_DEPTH) begin
            freq_tab[mode_index]  = mode_frequency;
            inten_tab[mode_index] = mode_intensity;
          end
        end else if (point_index != 0 && point_index <= GRID_LAST) begin
          spectrum_q.push_back(broaden(point_index));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH_SQ:   width_sq_q   = cfg_data[WSQ_W-1:0];
          CFG_MODE_COUNT: mode_count_q = cfg_data[MCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = spectrum_q.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for lorentzian_spectrum_broadening_top: clock, reset, stimulus and verdict.
// Directed corner cases, then random load/query phases with register changes while idle.
// Depends on lsb_pkg, the block and lsb_spectrum_checker.
`timescale 1ns / 100ps

module tb;
  import lsb_pkg::*;

  localparam int unsigned TABLE_DEPTH   = DEF_MODE_DEPTH;
  localparam int unsigned GRID_LAST     = DEF_GRID_POINTS;
  localparam int unsigned ITEM_TARGET   = 450;
  localparam int unsigned SETTLE_CYCLES = 300;   // longest query plus pipeline
  localparam int unsigned HOLD_CYCLES   = 1200;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned IDLE_PCT      = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_MODE_COUNT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action;
  logic [MIDX_W-1:0]     mode_index;
  logic [FREQ_W-1:0]     mode_frequency;
  logic [INTEN_W-1:0]    mode_intensity;
  logic [POINT_W-1:0]    point_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [GRIDF_W-1:0]    grid_frequency;
  logic [SUM_W-1:0]      spectrum_value;
  logic                  saturated;

  int          chk_errors;
  int          chk_pending;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet = 0;
  int unsigned filled = 0;     // leading table entries known written
  bit          written [TABLE_DEPTH];
  bit          held = 1'b0;

  always #5 clk = ~clk;

  lorentzian_spectrum_broadening_top dut (.*);

  lsb_spectrum_checker checker_i (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .action, .mode_index, .mode_frequency, .mode_intensity,
    .point_index, .out_valid, .out_ready, .grid_frequency, .spectrum_value, .saturated,
    .errors(chk_errors), .pending(chk_pending)
  );

  // Random payload pickers
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned r;
    int          f;
    r = $urandom_range(99, 0);
    if (r < 40) f = $urandom_range(66000, 0);
    else if (r < 60) f = 160 * $urandom_range(GRID_LAST, 1);
    else if (r < 70) f = 160 * $urandom_range(GRID_LAST, 1) + $urandom_range(400, 0) - 200;
    else f = $urandom();
    return FREQ_W'(f);
  endfunction

  function automatic logic [INTEN_W-1:0] pick_inten();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return $urandom();
    if (r < 75) return $urandom_range(1 << 20, 0);
    if (r < 88) return '0;
    return '1;
  endfunction

  function automatic logic [POINT_W-1:0] pick_point();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 2) return '0;
    if (r < 8) return POINT_W'($urandom_range((1 << POINT_W) - 1, GRID_LAST + 1));
    return POINT_W'($urandom_range(GRID_LAST, 1));
  endfunction

  function automatic logic [WSQ_W-1:0] pick_width();
    case ($urandom_range(4, 0))
      0: return WIDTH_SQ_RESET;
      1: return WSQ_W'(1);
      2: return '1;
      3: return $urandom_range(1000000, 1);
      default: return $urandom();
    endcase
  endfunction

  // One item beat; sender idles at random except in a quiet window
  task automatic send_item(logic act, logic [MIDX_W-1:0] idx, logic [FREQ_W-1:0] freq,
                           logic [INTEN_W-1:0] inten, logic [POINT_W-1:0] k);
    @(negedge clk);
    while ((items_sent < 200 || items_sent >= 300) && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    mode_index     <= idx;
    mode_frequency <= freq;
    mode_intensity <= inten;
    point_index    <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (act == ACT_LOAD) begin
      written[idx] = 1'b1;
      while (filled < TABLE_DEPTH && written[filled]) filled++;
    end
  endtask

  task automatic load_entry(logic [MIDX_W-1:0] idx);
    send_item(ACT_LOAD, idx, pick_freq(), pick_inten(), POINT_W'($urandom()));
  endtask

  task automatic query(logic [POINT_W-1:0] k);
    send_item(ACT_QUERY, MIDX_W'($urandom()), FREQ_W'($urandom()), $urandom(), k);
  endtask

  // Wait out every expected result plus the tail of a silent query
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (chk_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off while items keep coming
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 60 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= !((results_seen < 100 || results_seen >= 160) &&
                       $urandom_range(99, 0) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen <= results_seen + 1;
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned          r;
    int unsigned          need;
    int unsigned          batch;
    logic [MCOUNT_W-1:0]  count_val;
    logic [CFG_DATA_W-1:0] cdata;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    action         = ACT_LOAD;
    mode_index     = '0;
    mode_frequency = '0;
    mode_intensity = '0;
    point_index    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty sum at reset count, out-of-range points, grid ends
    query(POINT_W'(1));
    query('0);
    query('1);
    query(POINT_W'(GRID_LAST + 1));
    query(POINT_W'(GRID_LAST));
    // Exact peak at k=1, frequency and intensity extremes, last table slot
    send_item(ACT_LOAD, MIDX_W'(0), FREQ_W'(160), '1, '0);
    send_item(ACT_LOAD, MIDX_W'(1), 21'h100000, 32'h0001_0000, '1);
    send_item(ACT_LOAD, MIDX_W'(2), 21'h0FFFFF, '1, '0);
    send_item(ACT_LOAD, MIDX_W'(3), '1, 32'h0000_0001, '1);
    load_entry('1);
    settle();
    write_reg(CFG_MODE_COUNT, CFG_DATA_W'(4));
    query(POINT_W'(1));
    query(POINT_W'(GRID_LAST));
    query(POINT_W'(256));
    query(POINT_W'(200));
    // Zero width: exact peak has a zero denominator
    settle();
    write_reg(CFG_WIDTH_SQ, '0);
    query(POINT_W'(1));
    query(POINT_W'(2));
    settle();
    write_reg(CFG_WIDTH_SQ, '1);
    query(POINT_W'(1));
    query(POINT_W'(GRID_LAST));
    // Unknown register must leave the narrowest width in place
    settle();
    write_reg(CFG_WIDTH_SQ, CFG_DATA_W'(1));
    write_reg(CFG_IDX_TOP, $urandom());
    query(POINT_W'(1));
    settle();
    write_reg(CFG_WIDTH_SQ, CFG_DATA_W'(WIDTH_SQ_RESET));

    // Random phases: fill the table prefix, set registers while idle, then mixed beats
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(99, 0);
      if (r < 10) need = TABLE_DEPTH;
      else if (r < 30) need = $urandom_range(64, 0);
      else need = $urandom_range(12, 0);
      while (filled < need) load_entry(MIDX_W'(filled));
      settle();
      if ($urandom_range(1, 0)) write_reg(CFG_WIDTH_SQ, pick_width());
      if ($urandom_range(9, 0) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_TOP, CFG_IDX_SPARE)), $urandom());
      if (need >= TABLE_DEPTH && $urandom_range(1, 0))
        count_val = MCOUNT_W'($urandom_range((1 << MCOUNT_W) - 1, TABLE_DEPTH + 1));
      else
        count_val = MCOUNT_W'(need);
      cdata = {{(CFG_DATA_W - MCOUNT_W){1'b0}}, count_val};
      if ($urandom_range(1, 0)) cdata[CFG_DATA_W-1:MCOUNT_W] = $urandom();
      write_reg(CFG_MODE_COUNT, cdata);
      batch = (need >= TABLE_DEPTH) ? $urandom_range(6, 3) : $urandom_range(20, 8);
      repeat (batch) begin
        if ($urandom_range(99, 0) < 60) query(pick_point());
        else load_entry(MIDX_W'($urandom()));
      end
    end

    settle();
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
